// File: rtl/core/assert_macros.svh
// Assertion macros used by the port checker of this block.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock, switched off while reset is high.
`define CLDR_CHECK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check sampled on the rising clock, active during reset as well.
`define CLDR_CHECK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/cldr_pkg.sv
// Shared types, constants and helper functions of the console line discipline.
// Depends on nothing; the RTL modules and interfaces use it by scoped names, the testbench files import it.
`timescale 1ns / 1ps

package cldr_pkg;

  // Ring sizes and the widths that follow from them.
  localparam int RX_DEPTH = 256;
  localparam int TX_DEPTH = 256;
  localparam int RX_AW    = $clog2(RX_DEPTH);
  localparam int TX_AW    = $clog2(TX_DEPTH);
  localparam int RX_LW    = $clog2(RX_DEPTH + 1);
  localparam int TX_LW    = $clog2(TX_DEPTH + 1);

  // Line counter.
  localparam int          LINE_W   = 16;
  localparam logic [15:0] LINE_MAX = 16'hFFFF;

  // Command queue between the front and the back.
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // Operation codes on the request channel.
  localparam logic [2:0] OP_RX        = 3'd0;
  localparam logic [2:0] OP_TX_READY  = 3'd1;
  localparam logic [2:0] OP_HOST_READ = 3'd2;
  localparam logic [2:0] OP_HOST_PUT  = 3'd3;
  localparam logic [2:0] OP_LINE_DONE = 3'd4;
  localparam logic [2:0] OP_CLEAR     = 3'd5;

  // Status codes on the result channel.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_OVERRUN    = 3'd1;
  localparam logic [2:0] ST_PUT_FULL   = 3'd2;
  localparam logic [2:0] ST_READ_EMPTY = 3'd3;
  localparam logic [2:0] ST_ECHO_DROP  = 3'd4;

  // Characters with a special meaning.
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_CTRLR = 8'h12;
  localparam logic [7:0] CH_BELL  = 8'h07;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // What the back has to do for one request.
  typedef enum logic [2:0] {
    KIND_RX,
    KIND_TX,
    KIND_READ,
    KIND_PUT,
    KIND_LINE,
    KIND_CLEAR,
    KIND_NOP
  } kind_t;

  // Class of a received character.
  typedef enum logic [1:0] {
    CLS_OTHER,
    CLS_EOL,
    CLS_ERASE,
    CLS_REDRAW
  } cls_t;

  // Echo sequences written into the transmit ring.
  typedef enum logic [1:0] {
    ECHO_CHAR,
    ECHO_CRLF,
    ECHO_BELL,
    ECHO_ERASE
  } echo_t;

  // Classified request carried by the command queue.
  typedef struct packed {
    kind_t      kind;
    cls_t       cls;
    logic [7:0] data;
  } cmd_t;

  // One result as held in the output register.
  typedef struct packed {
    logic              tx_valid;
    logic [7:0]        tx_byte;
    logic              rx_valid;
    logic [7:0]        rx_byte;
    logic [RX_LW-1:0]  rx_level;
    logic [TX_LW-1:0]  tx_level;
    logic [LINE_W-1:0] lines_ready;
    logic [2:0]        status;
  } res_t;

  // Number of bytes in an echo sequence.
  function automatic logic [1:0] echo_len(input echo_t kind);
    logic [1:0] n;
    unique case (kind)
      ECHO_CHAR:  n = 2'd1;
      ECHO_CRLF:  n = 2'd2;
      ECHO_BELL:  n = 2'd1;
      ECHO_ERASE: n = 2'd3;
      default:    n = 2'd1;
    endcase
    return n;
  endfunction

  // Byte at a given place of an echo sequence.
  function automatic logic [7:0] echo_byte(input echo_t kind, input logic [1:0] idx,
                                           input logic [7:0] c);
    logic [7:0] b;
    unique case (kind)
      ECHO_CHAR:  b = c;
      ECHO_CRLF:  b = (idx == 2'd0) ? CH_CR : CH_LF;
      ECHO_BELL:  b = CH_BELL;
      ECHO_ERASE: b = (idx == 2'd1) ? CH_SPACE : CH_BS;
      default:    b = c;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/core/cldr_chan_if.sv
// Channel interfaces of the console line discipline: requests, results, configuration.
// Depends on cldr_pkg for the level and line count widths.
`timescale 1ns / 1ps

// Request channel: one operation and its data byte.
interface cldr_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] data_byte;

  modport source (output valid, op, data_byte, input ready);
  modport sink (input valid, op, data_byte, output ready);
endinterface

// Result channel: one result for every request.
interface cldr_out_if;
  logic                          valid;
  logic                          ready;
  logic                          tx_valid;
  logic [7:0]                    tx_byte;
  logic                          rx_valid;
  logic [7:0]                    rx_byte;
  logic [cldr_pkg::RX_LW-1:0]    rx_level;
  logic [cldr_pkg::TX_LW-1:0]    tx_level;
  logic [cldr_pkg::LINE_W-1:0]   lines_ready;
  logic [2:0]                    status;

  modport source (output valid, tx_valid, tx_byte, rx_valid, rx_byte, rx_level, tx_level,
                  lines_ready, status, input ready);
  modport sink (input valid, tx_valid, tx_byte, rx_valid, rx_byte, rx_level, tx_level,
                lines_ready, status, output ready);
endinterface

// Configuration channel: the echo enable bit.
interface cldr_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: rtl/core/cldr_front.sv
// Front of the console line discipline: takes requests, classifies them and queues them.
// Depends on cldr_pkg and the cldr_in_if interface.
`timescale 1ns / 1ps

module cldr_front (
  input  logic               clk,
  input  logic               rst,
  cldr_in_if.sink            item,
  output logic               cmd_valid,
  output cldr_pkg::cmd_t     cmd,
  input  logic               cmd_ready
);

  cldr_pkg::cmd_t                q [cldr_pkg::Q_DEPTH];
  logic [cldr_pkg::Q_AW-1:0]     wr_ptr;
  logic [cldr_pkg::Q_AW-1:0]     rd_ptr;
  logic [cldr_pkg::Q_CW-1:0]     count;
  cldr_pkg::cmd_t                new_cmd;
  logic                          push;
  logic                          pop;

  // Decode the operation and sort the character into its class.
  always_comb begin
    new_cmd.data = item.data_byte;
    unique case (item.op)
      cldr_pkg::OP_RX:        new_cmd.kind = cldr_pkg::KIND_RX;
      cldr_pkg::OP_TX_READY:  new_cmd.kind = cldr_pkg::KIND_TX;
      cldr_pkg::OP_HOST_READ: new_cmd.kind = cldr_pkg::KIND_READ;
      cldr_pkg::OP_HOST_PUT:  new_cmd.kind = cldr_pkg::KIND_PUT;
      cldr_pkg::OP_LINE_DONE: new_cmd.kind = cldr_pkg::KIND_LINE;
      cldr_pkg::OP_CLEAR:     new_cmd.kind = cldr_pkg::KIND_CLEAR;
      default:                new_cmd.kind = cldr_pkg::KIND_NOP;
    endcase
    priority if (item.data_byte == cldr_pkg::CH_LF || item.data_byte == cldr_pkg::CH_CR) begin
      new_cmd.cls = cldr_pkg::CLS_EOL;
    end else if (item.data_byte == cldr_pkg::CH_BS ||
                 item.data_byte == cldr_pkg::CH_DEL) begin
      new_cmd.cls = cldr_pkg::CLS_ERASE;
    end else if (item.data_byte == cldr_pkg::CH_CTRLR) begin
      new_cmd.cls = cldr_pkg::CLS_REDRAW;
    end else begin
      new_cmd.cls = cldr_pkg::CLS_OTHER;
    end
  end

  // Queue handshakes.
  assign item.ready = (count != cldr_pkg::Q_CW'(cldr_pkg::Q_DEPTH));
  assign push       = item.valid && item.ready;
  assign cmd_valid  = (count != '0);
  assign pop        = cmd_valid && cmd_ready;
  assign cmd        = q[rd_ptr];

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == cldr_pkg::Q_AW'(cldr_pkg::Q_DEPTH - 1)) ? '0 :
                  wr_ptr + cldr_pkg::Q_AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == cldr_pkg::Q_AW'(cldr_pkg::Q_DEPTH - 1)) ? '0 :
                  rd_ptr + cldr_pkg::Q_AW'(1);
      end
      if (push && !pop) begin
        count <= count + cldr_pkg::Q_CW'(1);
      end else if (pop && !push) begin
        count <= count - cldr_pkg::Q_CW'(1);
      end
    end
  end

  // Queue entries.
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= new_cmd;
    end
  end

endmodule

// File: rtl/core/cldr_back.sv
// Back of the console line discipline: ring memories, line editing, echo and results.
// Depends on cldr_pkg and the cldr_out_if and cldr_cfg_if interfaces.
`timescale 1ns / 1ps

module cldr_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  cldr_pkg::cmd_t     cmd,
  output logic               cmd_ready,
  cldr_out_if.source         result,
  cldr_cfg_if.sink           cfg
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_ECHO,
    S_DONE
  } state_t;

  // Ring memories.
  logic [7:0] rx_mem [cldr_pkg::RX_DEPTH];
  logic [7:0] tx_mem [cldr_pkg::TX_DEPTH];

  // Sequencer state and ring bookkeeping.
  state_t                          state, state_next;
  cldr_pkg::cmd_t                  cur, cur_next;
  logic [cldr_pkg::RX_AW-1:0]      rx_head, rx_head_next, rx_tail, rx_tail_next;
  logic [cldr_pkg::RX_LW-1:0]      rx_fill, rx_fill_next;
  logic [cldr_pkg::TX_AW-1:0]      tx_head, tx_head_next, tx_tail, tx_tail_next;
  logic [cldr_pkg::TX_LW-1:0]      tx_fill, tx_fill_next;
  logic [cldr_pkg::LINE_W-1:0]     line_total, line_total_next;
  logic                            echo_enable, echo_enable_next;
  cldr_pkg::echo_t                 echo_kind, echo_kind_next;
  logic [1:0]                      echo_idx, echo_idx_next;

  // Result under construction and the output register.
  logic                            w_tx_valid, w_tx_valid_next;
  logic [7:0]                      w_tx_byte, w_tx_byte_next;
  logic                            w_rx_valid, w_rx_valid_next;
  logic [7:0]                      w_rx_byte, w_rx_byte_next;
  logic [2:0]                      w_status, w_status_next;
  logic                            out_valid, out_valid_next;
  cldr_pkg::res_t                  out_res, out_res_next;

  // Memory ports.
  logic                            rx_we, rx_re;
  logic [cldr_pkg::RX_AW-1:0]      rx_waddr, rx_raddr;
  logic [7:0]                      rx_wdata, rx_rdata;
  logic                            tx_we, tx_re;
  logic [cldr_pkg::TX_AW-1:0]      tx_waddr, tx_raddr;
  logic [7:0]                      tx_wdata, tx_rdata;

  function automatic logic [cldr_pkg::RX_AW-1:0] rx_inc(input logic [cldr_pkg::RX_AW-1:0] p);
    return (p == cldr_pkg::RX_AW'(cldr_pkg::RX_DEPTH - 1)) ? '0 : p + cldr_pkg::RX_AW'(1);
  endfunction

  function automatic logic [cldr_pkg::RX_AW-1:0] rx_dec(input logic [cldr_pkg::RX_AW-1:0] p);
    return (p == '0) ? cldr_pkg::RX_AW'(cldr_pkg::RX_DEPTH - 1) : p - cldr_pkg::RX_AW'(1);
  endfunction

  function automatic logic [cldr_pkg::TX_AW-1:0] tx_inc(input logic [cldr_pkg::TX_AW-1:0] p);
    return (p == cldr_pkg::TX_AW'(cldr_pkg::TX_DEPTH - 1)) ? '0 : p + cldr_pkg::TX_AW'(1);
  endfunction

  assign cmd_ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  // Result port driven from the output register.
  assign result.valid       = out_valid;
  assign result.tx_valid    = out_res.tx_valid;
  assign result.tx_byte     = out_res.tx_byte;
  assign result.rx_valid    = out_res.rx_valid;
  assign result.rx_byte     = out_res.rx_byte;
  assign result.rx_level    = out_res.rx_level;
  assign result.tx_level    = out_res.tx_level;
  assign result.lines_ready = out_res.lines_ready;
  assign result.status      = out_res.status;

  // Sequencer: next state, ring updates and memory port control.
  always_comb begin
    logic [cldr_pkg::RX_AW-1:0]  rx_h;
    logic [cldr_pkg::RX_LW-1:0]  rx_f;
    logic [cldr_pkg::LINE_W-1:0] lines;
    logic                        echo_req;
    cldr_pkg::echo_t             echo_sel;
    logic [cldr_pkg::TX_LW:0]    room_sum;

    state_next       = state;
    cur_next         = cur;
    rx_head_next     = rx_head;
    rx_tail_next     = rx_tail;
    rx_fill_next     = rx_fill;
    tx_head_next     = tx_head;
    tx_tail_next     = tx_tail;
    tx_fill_next     = tx_fill;
    line_total_next  = line_total;
    echo_enable_next = cfg.valid ? cfg.data : echo_enable;
    echo_kind_next   = echo_kind;
    echo_idx_next    = echo_idx;
    w_tx_valid_next  = w_tx_valid;
    w_tx_byte_next   = w_tx_byte;
    w_rx_valid_next  = w_rx_valid;
    w_rx_byte_next   = w_rx_byte;
    w_status_next    = w_status;
    out_res_next     = out_res;
    out_valid_next   = out_valid && !result.ready;

    rx_we    = 1'b0;
    rx_waddr = rx_head;
    rx_wdata = cmd.data;
    rx_re    = 1'b0;
    rx_raddr = rx_tail;
    tx_we    = 1'b0;
    tx_waddr = tx_head;
    tx_wdata = cmd.data;
    tx_re    = 1'b0;
    tx_raddr = tx_tail;

    rx_h     = rx_head;
    rx_f     = rx_fill;
    lines    = line_total;
    echo_req = 1'b0;
    echo_sel = cldr_pkg::ECHO_CHAR;

    unique case (state)
      // Take one request and do its first step.
      S_IDLE: begin
        if (cmd_valid) begin
          cur_next        = cmd;
          state_next      = S_DONE;
          w_tx_valid_next = 1'b0;
          w_tx_byte_next  = '0;
          w_rx_valid_next = 1'b0;
          w_rx_byte_next  = '0;
          w_status_next   = cldr_pkg::ST_OK;
          unique case (cmd.kind)
            cldr_pkg::KIND_RX: begin
              // A nearly full receive ring is emptied before the byte is handled.
              if (rx_fill >= cldr_pkg::RX_LW'(cldr_pkg::RX_DEPTH - 2)) begin
                rx_h          = '0;
                rx_f          = '0;
                lines         = '0;
                rx_tail_next  = '0;
                w_status_next = cldr_pkg::ST_OVERRUN;
              end
              rx_head_next    = rx_h;
              rx_fill_next    = rx_f;
              line_total_next = lines;
              unique case (cmd.cls)
                cldr_pkg::CLS_EOL: begin
                  rx_we           = 1'b1;
                  rx_waddr        = rx_h;
                  rx_wdata        = cldr_pkg::CH_LF;
                  rx_head_next    = rx_inc(rx_h);
                  rx_fill_next    = rx_f + cldr_pkg::RX_LW'(1);
                  line_total_next = (lines == cldr_pkg::LINE_MAX) ? lines :
                                    lines + cldr_pkg::LINE_W'(1);
                  echo_req        = 1'b1;
                  echo_sel        = cldr_pkg::ECHO_CRLF;
                end
                cldr_pkg::CLS_ERASE: begin
                  if (rx_f == '0) begin
                    echo_req = 1'b1;
                    echo_sel = cldr_pkg::ECHO_BELL;
                  end else begin
                    // The last stored byte decides between erase and bell.
                    rx_re      = 1'b1;
                    rx_raddr   = rx_dec(rx_h);
                    state_next = S_READ;
                  end
                end
                cldr_pkg::CLS_REDRAW: begin
                  rx_head_next    = '0;
                  rx_tail_next    = '0;
                  rx_fill_next    = '0;
                  line_total_next = '0;
                end
                default: begin
                  rx_we        = 1'b1;
                  rx_waddr     = rx_h;
                  rx_wdata     = cmd.data;
                  rx_head_next = rx_inc(rx_h);
                  rx_fill_next = rx_f + cldr_pkg::RX_LW'(1);
                  echo_req     = 1'b1;
                  echo_sel     = cldr_pkg::ECHO_CHAR;
                end
              endcase
            end
            cldr_pkg::KIND_TX: begin
              if (tx_fill != '0) begin
                tx_re      = 1'b1;
                tx_raddr   = tx_tail;
                state_next = S_READ;
              end
            end
            cldr_pkg::KIND_READ: begin
              if (rx_fill != '0) begin
                rx_re      = 1'b1;
                rx_raddr   = rx_tail;
                state_next = S_READ;
              end else begin
                w_status_next = cldr_pkg::ST_READ_EMPTY;
              end
            end
            cldr_pkg::KIND_PUT: begin
              // Four places stay free for echoes.
              if (tx_fill >= cldr_pkg::TX_LW'(cldr_pkg::TX_DEPTH - 4)) begin
                w_status_next = cldr_pkg::ST_PUT_FULL;
              end else begin
                tx_we        = 1'b1;
                tx_waddr     = tx_head;
                tx_wdata     = cmd.data;
                tx_head_next = tx_inc(tx_head);
                tx_fill_next = tx_fill + cldr_pkg::TX_LW'(1);
              end
            end
            cldr_pkg::KIND_LINE: begin
              if (line_total != '0) begin
                line_total_next = line_total - cldr_pkg::LINE_W'(1);
              end
            end
            cldr_pkg::KIND_CLEAR: begin
              rx_head_next    = '0;
              rx_tail_next    = '0;
              rx_fill_next    = '0;
              tx_head_next    = '0;
              tx_tail_next    = '0;
              tx_fill_next    = '0;
              line_total_next = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // Registered memory data is back: finish the pop or the erase.
      S_READ: begin
        state_next = S_DONE;
        unique case (cur.kind)
          cldr_pkg::KIND_RX: begin
            echo_req = 1'b1;
            if (rx_rdata == cldr_pkg::CH_LF) begin
              echo_sel = cldr_pkg::ECHO_BELL;
            end else begin
              rx_fill_next = rx_fill - cldr_pkg::RX_LW'(1);
              rx_head_next = rx_dec(rx_head);
              echo_sel     = cldr_pkg::ECHO_ERASE;
            end
          end
          cldr_pkg::KIND_TX: begin
            w_tx_valid_next = 1'b1;
            w_tx_byte_next  = tx_rdata;
            tx_tail_next    = tx_inc(tx_tail);
            tx_fill_next    = tx_fill - cldr_pkg::TX_LW'(1);
          end
          cldr_pkg::KIND_READ: begin
            w_rx_valid_next = 1'b1;
            w_rx_byte_next  = rx_rdata;
            rx_tail_next    = rx_inc(rx_tail);
            rx_fill_next    = rx_fill - cldr_pkg::RX_LW'(1);
          end
          default: begin
          end
        endcase
      end

      // Write the echo sequence into the transmit ring, one byte a cycle.
      S_ECHO: begin
        tx_we         = 1'b1;
        tx_waddr      = tx_head;
        tx_wdata      = cldr_pkg::echo_byte(echo_kind, echo_idx, cur.data);
        tx_head_next  = tx_inc(tx_head);
        tx_fill_next  = tx_fill + cldr_pkg::TX_LW'(1);
        echo_idx_next = echo_idx + 2'd1;
        if (echo_idx == cldr_pkg::echo_len(echo_kind) - 2'd1) begin
          state_next = S_DONE;
        end
      end

      // Load the output register once it is free.
      S_DONE: begin
        if (!out_valid || result.ready) begin
          out_valid_next           = 1'b1;
          out_res_next.tx_valid    = w_tx_valid;
          out_res_next.tx_byte     = w_tx_byte;
          out_res_next.rx_valid    = w_rx_valid;
          out_res_next.rx_byte     = w_rx_byte;
          out_res_next.rx_level    = rx_fill;
          out_res_next.tx_level    = tx_fill;
          out_res_next.lines_ready = line_total;
          out_res_next.status      = w_status;
          state_next               = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // An echo goes in whole when the transmit ring has room, else it is dropped.
    room_sum = {1'b0, tx_fill} + (cldr_pkg::TX_LW + 1)'(cldr_pkg::echo_len(echo_sel));
    if (echo_req && echo_enable) begin
      if (room_sum > (cldr_pkg::TX_LW + 1)'(cldr_pkg::TX_DEPTH)) begin
        if (w_status_next == cldr_pkg::ST_OK) begin
          w_status_next = cldr_pkg::ST_ECHO_DROP;
        end
      end else begin
        state_next     = S_ECHO;
        echo_kind_next = echo_sel;
        echo_idx_next  = '0;
      end
    end
  end

  // State, control registers and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rx_head     <= '0;
      rx_tail     <= '0;
      rx_fill     <= '0;
      tx_head     <= '0;
      tx_tail     <= '0;
      tx_fill     <= '0;
      line_total  <= '0;
      echo_enable <= 1'b1;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      rx_head     <= rx_head_next;
      rx_tail     <= rx_tail_next;
      rx_fill     <= rx_fill_next;
      tx_head     <= tx_head_next;
      tx_tail     <= tx_tail_next;
      tx_fill     <= tx_fill_next;
      line_total  <= line_total_next;
      echo_enable <= echo_enable_next;
      out_valid   <= out_valid_next;
    end
    cur        <= cur_next;
    echo_kind  <= echo_kind_next;
    echo_idx   <= echo_idx_next;
    w_tx_valid <= w_tx_valid_next;
    w_tx_byte  <= w_tx_byte_next;
    w_rx_valid <= w_rx_valid_next;
    w_rx_byte  <= w_rx_byte_next;
    w_status   <= w_status_next;
    out_res    <= out_res_next;
  end

  // Receive ring memory: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[rx_waddr] <= rx_wdata;
    end
    if (rx_re) begin
      rx_rdata <= rx_mem[rx_raddr];
    end
  end

  // Transmit ring memory: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[tx_waddr] <= tx_wdata;
    end
    if (tx_re) begin
      tx_rdata <= tx_mem[tx_raddr];
    end
  end

endmodule

// File: rtl/core/console_line_discipline_rings_top.sv
// Top level of the console line discipline: front classifier, command queue and back.
// Depends on cldr_pkg, the channel interfaces, cldr_front and cldr_back.
//
//   Channel  | Dir | Payload                                       | Handshake
//   item     | in  | op, data_byte                                 | valid / ready
//   result   | out | tx/rx bytes and valids, levels, lines, status | valid / ready
//   cfg      | in  | data (echo enable)                            | valid / ready
//
// The back handles a request in its idle and done states; a pop from a ring adds a read
// state (registered memory read), and an echo adds an echo state that writes it byte by
// byte, since the transmit ring has a single write port; the erase with echo is longest.
// A two-entry command queue takes requests while the back works or a result waits.
// Reset is synchronous; the ring memories need no clearing pass, as only written
// entries are ever read. Configuration is taken in any cycle.
`timescale 1ns / 1ps

module console_line_discipline_rings_top (
  input  logic       clk,
  input  logic       rst,
  cldr_in_if.sink    item,
  cldr_out_if.source result,
  cldr_cfg_if.sink   cfg
);

  logic           cmd_valid;
  logic           cmd_ready;
  cldr_pkg::cmd_t cmd;

  // Request classification and queueing.
  cldr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready)
  );

  // Ring handling, editing, echo and results.
  cldr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .result    (result),
    .cfg       (cfg)
  );

endmodule

// File: rtl/core/cldr_checker.sv
// Port-level checks of the console line discipline, bound to its top level.
// Depends on cldr_pkg, assert_macros.svh and console_line_discipline_rings_top.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cldr_port_checks (
  input logic                         clk,
  input logic                         rst,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic                         tx_valid,
  input logic [7:0]                   tx_byte,
  input logic                         rx_valid,
  input logic [7:0]                   rx_byte,
  input logic [cldr_pkg::RX_LW-1:0]   rx_level,
  input logic [cldr_pkg::TX_LW-1:0]   tx_level,
  input logic [2:0]                   status
);

  // A result that is not taken stays, unchanged.
  `CLDR_CHECK(a_res_hold, clk, rst, res_valid && !res_ready |=> res_valid && $stable(tx_byte) && $stable(rx_byte) && $stable(rx_level) && $stable(tx_level) && $stable(status), "result changed while stalled")

  // Byte fields are zero unless their valid flag is set.
  `CLDR_CHECK(a_bytes_zero, clk, rst, res_valid |-> (tx_valid || tx_byte == 8'd0) && (rx_valid || rx_byte == 8'd0), "byte set without its valid flag")

  // Ring levels never exceed the ring sizes.
  `CLDR_CHECK(a_levels, clk, rst, res_valid |-> rx_level <= cldr_pkg::RX_DEPTH && tx_level <= cldr_pkg::TX_DEPTH, "ring level out of range")

  // A read of an empty ring returns no byte and leaves the ring empty.
  `CLDR_CHECK(a_read_empty, clk, rst, res_valid && status == cldr_pkg::ST_READ_EMPTY |-> !rx_valid && rx_level == '0, "empty read inconsistent")

  // No result is shown right after reset.
  `CLDR_CHECK_ALWAYS(a_reset_idle, clk, rst |=> !res_valid, "result valid after reset")

endmodule

bind console_line_discipline_rings_top cldr_port_checks u_port_checks (
  .clk       (clk),
  .rst       (rst),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .tx_valid  (result.tx_valid),
  .tx_byte   (result.tx_byte),
  .rx_valid  (result.rx_valid),
  .rx_byte   (result.rx_byte),
  .rx_level  (result.rx_level),
  .tx_level  (result.tx_level),
  .status    (result.status)
);

// File: tb/cldr_checker.sv
// Checker for the console line discipline: watches the request, result and configuration
// channels, keeps its own copy of both rings and the line count, and checks every result.
// Depends on cldr_pkg and the channel interfaces of the block.
`timescale 1ns / 1ps

module cldr_checker (
  input  logic clk,
  input  logic rst,
  cldr_in_if   item,
  cldr_out_if  result,
  cldr_cfg_if  cfg,
  output int   due_count,
  output int   mismatch_cnt,
  output int   checked_cnt
);
  import cldr_pkg::*;

  // Modeled state of the console: two rings, the line count and the echo switch.
  logic [7:0]        rx_mem [RX_DEPTH];
  logic [7:0]        tx_mem [TX_DEPTH];
  logic [RX_AW-1:0]  rx_wr;
  logic [RX_AW-1:0]  rx_rd;
  logic [RX_LW-1:0]  rx_fill;
  logic [TX_AW-1:0]  tx_wr;
  logic [TX_AW-1:0]  tx_rd;
  logic [TX_LW-1:0]  tx_fill;
  logic [LINE_W-1:0] line_cnt;
  logic              echo_on;

  // Results owed by the block, oldest request first.
  res_t results_due [$];

  // Emptying the receive side also forgets every counted line.
  function automatic void empty_rx_ring();
    rx_wr = '0;
    rx_rd = '0;
    rx_fill = '0;
    line_cnt = '0;
  endfunction

  function automatic void put_rx(input logic [7:0] b);
    rx_mem[rx_wr] = b;
    rx_wr = rx_wr + 1'b1;
    rx_fill = rx_fill + 1'b1;
  endfunction

  function automatic void put_tx(input logic [7:0] b);
    tx_mem[tx_wr] = b;
    tx_wr = tx_wr + 1'b1;
    tx_fill = tx_fill + 1'b1;
  endfunction

  // An echo goes into the transmit ring whole or not at all; returns 1 when it is dropped.
  function automatic logic queue_echo(input logic [7:0] b0, input logic [7:0] b1,
                                      input logic [7:0] b2, input int n);
    logic [7:0] seq [3];
    if (!echo_on) return 1'b0;
    if (tx_fill + n > TX_DEPTH) return 1'b1;
    seq[0] = b0;
    seq[1] = b1;
    seq[2] = b2;
    for (int i = 0; i < n; i++) put_tx(seq[i]);
    return 1'b0;
  endfunction

  // Applies one request to the modeled console and returns the result it must produce.
  function automatic res_t console_step(input logic [2:0] op, input logic [7:0] c);
    res_t             r;
    logic [RX_AW-1:0] last;
    logic             dropped;
    r = '0;
    dropped = 1'b0;
    case (op)
      OP_RX: begin
        // A nearly full receive ring is thrown away before the byte is handled.
        if (rx_fill >= RX_DEPTH - 2) begin
          empty_rx_ring();
          r.status = ST_OVERRUN;
        end
        if (c == CH_LF || c == CH_CR) begin
          put_rx(CH_LF);
          if (line_cnt != LINE_MAX) line_cnt = line_cnt + 1'b1;
          dropped = queue_echo(CH_CR, CH_LF, 8'h00, 2);
        end else if (c == CH_BS || c == CH_DEL) begin
          // Erasing never reaches past the end of a finished line.
          last = rx_wr - 1'b1;
          if (rx_fill == 0 || rx_mem[last] == CH_LF) begin
            dropped = queue_echo(CH_BELL, 8'h00, 8'h00, 1);
          end else begin
            rx_wr = last;
            rx_fill = rx_fill - 1'b1;
            dropped = queue_echo(CH_BS, CH_SPACE, CH_BS, 3);
          end
        end else if (c == CH_CTRLR) begin
          empty_rx_ring();
        end else begin
          put_rx(c);
          dropped = queue_echo(c, 8'h00, 8'h00, 1);
        end
        if (dropped && r.status == ST_OK) r.status = ST_ECHO_DROP;
      end
      OP_TX_READY: begin
        if (tx_fill != 0) begin
          r.tx_valid = 1'b1;
          r.tx_byte = tx_mem[tx_rd];
          tx_rd = tx_rd + 1'b1;
          tx_fill = tx_fill - 1'b1;
        end
      end
      OP_HOST_READ: begin
        if (rx_fill != 0) begin
          r.rx_valid = 1'b1;
          r.rx_byte = rx_mem[rx_rd];
          rx_rd = rx_rd + 1'b1;
          rx_fill = rx_fill - 1'b1;
        end else begin
          r.status = ST_READ_EMPTY;
        end
      end
      OP_HOST_PUT: begin
        // The last four places stay free for echoes.
        if (tx_fill >= TX_DEPTH - 4) r.status = ST_PUT_FULL;
        else put_tx(c);
      end
      OP_LINE_DONE: begin
        if (line_cnt != 0) line_cnt = line_cnt - 1'b1;
      end
      OP_CLEAR: begin
        empty_rx_ring();
        tx_wr = '0;
        tx_rd = '0;
        tx_fill = '0;
      end
      default: begin
      end
    endcase
    r.rx_level = rx_fill;
    r.tx_level = tx_fill;
    r.lines_ready = line_cnt;
    return r;
  endfunction

  function automatic string show(input res_t r);
    return $sformatf("tx %0b/%02h rx %0b/%02h levels rx %0d tx %0d lines %0d status %0d",
                     r.tx_valid, r.tx_byte, r.rx_valid, r.rx_byte, r.rx_level, r.tx_level,
                     r.lines_ready, r.status);
  endfunction

  // Everything is sampled at the rising edge; the stimulus only changes after it.
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst) begin
      empty_rx_ring();
      tx_wr = '0;
      tx_rd = '0;
      tx_fill = '0;
      echo_on = 1'b1;
      results_due.delete();
      mismatch_cnt = 0;
      checked_cnt = 0;
    end else begin
      // Results come back in request order, so each one meets the oldest open request.
      if (result.valid && result.ready) begin
        got.tx_valid = result.tx_valid;
        got.tx_byte = result.tx_byte;
        got.rx_valid = result.rx_valid;
        got.rx_byte = result.rx_byte;
        got.rx_level = result.rx_level;
        got.tx_level = result.tx_level;
        got.lines_ready = result.lines_ready;
        got.status = result.status;
        if (results_due.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: result with no open request: %s", $time, show(got));
        end else begin
          want = results_due.pop_front();
          checked_cnt++;
          if (got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
              got.rx_valid !== want.rx_valid || got.rx_byte !== want.rx_byte ||
              got.rx_level !== want.rx_level || got.tx_level !== want.tx_level ||
              got.lines_ready !== want.lines_ready || got.status !== want.status) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("%0t: result differs, expected %s", $time, show(want));
              $display("%0t:                  actual %s", $time, show(got));
            end
          end
        end
      end
      if (cfg.valid && cfg.ready) echo_on = cfg.data;
      if (item.valid && item.ready)
        results_due.push_back(console_step(item.op, item.data_byte));
    end
    due_count <= results_due.size();
  end

endmodule

// File: tb/tb_top.sv
// Testbench top for the console line discipline: clock, reset, request and config stimulus.
// Depends on cldr_pkg, the channel interfaces, the block's top level and cldr_checker.
`timescale 1ns / 1ps

module tb_top;
  import cldr_pkg::*;

  // Codes the block has no use for; they must leave everything alone.
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int MIXED_ITEMS = 160;

  logic clk;
  logic rst;
  logic idle_ok;
  int   due_count;
  int   mismatch_cnt;
  int   checked_cnt;
  int   cycle_cnt;
  int   stall_left;
  int   items_total;
  int   cfg_writes;
  int   op_seen [8];

  cldr_in_if  item_ch ();
  cldr_out_if result_ch ();
  cldr_cfg_if cfg_ch ();

  console_line_discipline_rings_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  cldr_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .item         (item_ch),
    .result       (result_ch),
    .cfg          (cfg_ch),
    .due_count    (due_count),
    .mismatch_cnt (mismatch_cnt),
    .checked_cnt  (checked_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit for a hung block.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: ready drops in random bursts while idling is allowed.
  initial begin
    result_ch.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else if (idle_ok && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Presents one request, sometimes after a gap, and returns at the edge that takes it.
  task automatic issue_request(input logic [2:0] op, input logic [7:0] d);
    if (idle_ok && $urandom_range(0, 5) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.op <= op;
    item_ch.data_byte <= d;
    op_seen[op]++;
    items_total++;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  // Stops sending and waits for every open request to come back.
  task automatic await_quiet();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
  endtask

  // The echo switch is only changed while the block has nothing in flight.
  task automatic set_echo(input logic v);
    await_quiet();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    cfg_writes++;
  endtask

  // One line typed with edits and some stray traffic, then read back and consumed.
  task automatic type_line();
    int n;
    int r;
    n = $urandom_range(1, 24);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 8) issue_request(OP_RX, r[0] ? CH_BS : CH_DEL);
      else if (r < 10) issue_request(OP_RX, CH_CTRLR);
      else if (r < 14) issue_request(3'($urandom_range(0, 7)), 8'($urandom));
      else if (r < 22) issue_request(OP_TX_READY, 8'($urandom));
      else issue_request(OP_RX, 8'($urandom));
    end
    issue_request(OP_RX, $urandom_range(0, 1) ? CH_CR : CH_LF);
    repeat ($urandom_range(0, n + 3)) issue_request(OP_HOST_READ, 8'($urandom));
    repeat ($urandom_range(0, 2 * n + 4)) issue_request(OP_TX_READY, 8'($urandom));
    issue_request(OP_LINE_DONE, 8'($urandom));
  endtask

  // Random received byte that neither ends a line, erases nor clears the ring.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == CH_BS || b == CH_DEL || b == CH_CTRLR || b == CH_CR || b == CH_LF) b = CH_SPACE;
    return b;
  endfunction

  initial begin
    int base;
    rst <= 1'b1;
    idle_ok <= 1'b1;
    item_ch.valid <= 1'b0;
    item_ch.op <= OP_RX;
    item_ch.data_byte <= 8'h00;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= 1'b0;
    items_total = 0;
    cfg_writes = 0;
    foreach (op_seen[i]) op_seen[i] = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed requests with echo at its reset value: empty rings, edits at the ring
    // start and after a finished line, byte extremes, redraw, puts, spare codes, clear.
    issue_request(OP_HOST_READ, 8'h00);
    issue_request(OP_TX_READY, 8'hFF);
    issue_request(OP_LINE_DONE, 8'h00);
    issue_request(OP_RX, CH_BS);
    issue_request(OP_RX, 8'h00);
    issue_request(OP_RX, 8'hFF);
    issue_request(OP_RX, CH_DEL);
    issue_request(OP_RX, CH_CR);
    issue_request(OP_RX, CH_BS);
    issue_request(OP_RX, CH_LF);
    issue_request(OP_LINE_DONE, 8'hFF);
    issue_request(OP_HOST_READ, 8'hFF);
    issue_request(OP_HOST_READ, 8'h00);
    issue_request(OP_RX, CH_CTRLR);
    issue_request(OP_HOST_READ, 8'h00);
    issue_request(OP_HOST_PUT, 8'h55);
    issue_request(OP_HOST_PUT, 8'hAA);
    repeat (3) issue_request(OP_TX_READY, 8'h00);
    issue_request(OP_SPARE_LO, 8'hFF);
    issue_request(OP_SPARE_HI, 8'h00);
    issue_request(OP_CLEAR, 8'h00);
    issue_request(OP_TX_READY, 8'h00);
    issue_request(OP_LINE_DONE, 8'h00);

    // Echo on with nothing drained: two puts and 254 typed bytes fill both rings, so
    // the next byte overruns the receive ring while its echo drops.
    set_echo(1'b1);
    repeat (2) issue_request(OP_HOST_PUT, 8'($urandom));
    repeat (254) issue_request(OP_RX, plain_byte());
    issue_request(OP_RX, plain_byte());
    issue_request(OP_RX, plain_byte());

    // Full transmit ring: an erase echo drops, a put is refused, then a little room
    // lets an erase through exactly, and bells on an empty ring or after LF drop.
    issue_request(OP_RX, CH_BS);
    issue_request(OP_HOST_PUT, 8'h64);
    repeat (3) issue_request(OP_TX_READY, 8'($urandom));
    issue_request(OP_RX, CH_BS);
    issue_request(OP_RX, CH_DEL);
    repeat (2) issue_request(OP_TX_READY, 8'($urandom));
    issue_request(OP_RX, CH_CR);
    issue_request(OP_RX, CH_BS);
    repeat (20) issue_request(OP_TX_READY, 8'($urandom));
    issue_request(OP_CLEAR, 8'($urandom));

    // Mixed traffic: mostly typed lines, some noise, random echo and idling settings,
    // and now and then a pause until all results are back.
    base = items_total;
    while (items_total - base < MIXED_ITEMS) begin
      int pick;
      idle_ok <= ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 9);
      if (pick == 0) set_echo(1'($urandom_range(0, 1)));
      else if (pick == 1) await_quiet();
      if (pick < 7) begin
        type_line();
      end else begin
        repeat ($urandom_range(8, 20))
          issue_request(3'($urandom_range(0, 7)), 8'($urandom));
      end
    end

    // Last part without idling: typed lines back to back with echo on.
    idle_ok <= 1'b0;
    set_echo(1'b1);
    repeat (2) type_line();

    await_quiet();
    repeat (8) @(posedge clk);

    $display("Covered %0d requests: %0d received, %0d tx pulls, %0d reads, %0d puts,",
             items_total, op_seen[OP_RX], op_seen[OP_TX_READY], op_seen[OP_HOST_READ],
             op_seen[OP_HOST_PUT]);
    $display("%0d line consumes, %0d clears, %0d spare codes, %0d echo writes, %0d checked.",
             op_seen[OP_LINE_DONE], op_seen[OP_CLEAR], op_seen[OP_SPARE_LO] +
             op_seen[OP_SPARE_HI], cfg_writes, checked_cnt);
    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
